FILE: src/mels_pkg.sv
package mels_pkg;

    localparam logic [15:0] UNIT_CR = 16'h000D;
    localparam logic [15:0] UNIT_LF = 16'h000A;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDE_UNITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SWAP_BYTES = 2'd1;

    localparam logic OP_UNIT = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    // result queue, depth must be a power of two so the pointers wrap
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RES     = 3;

    typedef struct packed {
        logic        op;
        logic [15:0] code_unit;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_unit;
        logic        has_unit;
        logic        line_end;
    } out_item_t;

endpackage

FILE: src/mixed_eol_line_splitter.sv
// an item is registered at the input, decoded into up to three results and
// written into the result queue, whose head is offered at the output
// throughput: one item per cycle while the 4-entry result queue has room for all
// results of the item in the input register; results leave at one per cycle unless stalled
// reset (rst_n low, asynchronous): no held CR, no open line, queue empty, bytes mode
module mixed_eol_line_splitter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                src_valid,
    output logic                                src_stall,
    input  mels_pkg::in_item_t                  src_item,
    output logic                                dst_valid,
    input  logic                                dst_stall,
    output mels_pkg::out_item_t                 dst_item,
    input  logic                                cfg_we,
    input  logic [mels_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic                                cfg_data
);

    logic                  wide_units_reg;
    logic                  swap_bytes_reg;
    logic [1:0]            pending_cr_reg, pending_cr_next;
    logic                  line_open_reg, line_open_next;

    logic                  in_vld_reg;
    mels_pkg::in_item_t    in_item_reg;

    mels_pkg::out_item_t   queue_mem [mels_pkg::QUEUE_DEPTH];
    logic [mels_pkg::PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [mels_pkg::CNT_W-1:0] count_reg, count_next;

    logic [15:0]           unit;
    logic [1:0]            cr_cnt;
    logic                  cr_end0, cr_end1;
    logic                  tail_en;
    mels_pkg::out_item_t   tail_item;
    mels_pkg::out_item_t   cr0_item, cr1_item;
    mels_pkg::out_item_t   slot [mels_pkg::MAX_RES];
    logic [1:0]            res_n;
    logic                  fire, accept, pop;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_units_reg <= 1'b0;
            swap_bytes_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mels_pkg::REG_WIDE_UNITS: wide_units_reg <= cfg_data;
                mels_pkg::REG_SWAP_BYTES: swap_bytes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // unit after width select and byte swap
    always_comb
    begin
        if (wide_units_reg)
            unit = swap_bytes_reg ? {in_item_reg.code_unit[7:0], in_item_reg.code_unit[15:8]}
                                  : in_item_reg.code_unit;
        else
            unit = {8'h00, in_item_reg.code_unit[7:0]};
    end

    // results are a run of held CRs followed by at most one other item
    always_comb
    begin
        cr_cnt          = 2'd0;
        cr_end0         = 1'b1;
        cr_end1         = 1'b1;
        tail_en         = 1'b0;
        tail_item       = '0;
        pending_cr_next = pending_cr_reg;
        line_open_next  = line_open_reg;
        if (in_item_reg.op == mels_pkg::OP_EOF)
        begin
            pending_cr_next = 2'd0;
            line_open_next  = 1'b0;
            if (pending_cr_reg == 2'd1)
                cr_cnt = 2'd1;
            else if (pending_cr_reg >= 2'd2)
            begin
                // CR CR at end of file stays one line
                cr_cnt  = 2'd2;
                cr_end0 = 1'b0;
            end
            else if (line_open_reg)
            begin
                tail_en   = 1'b1;
                tail_item = '{out_unit: 16'h0000, has_unit: 1'b0, line_end: 1'b1};
            end
        end
        else if (unit == mels_pkg::UNIT_LF)
        begin
            cr_cnt          = pending_cr_reg;
            cr_end0         = 1'b0;
            cr_end1         = 1'b0;
            tail_en         = 1'b1;
            tail_item       = '{out_unit: mels_pkg::UNIT_LF, has_unit: 1'b1, line_end: 1'b1};
            pending_cr_next = 2'd0;
            line_open_next  = 1'b0;
        end
        else if (unit == mels_pkg::UNIT_CR)
        begin
            line_open_next = 1'b0;
            if (pending_cr_reg >= 2'd2)
            begin
                cr_cnt          = 2'd2;
                pending_cr_next = 2'd1;
            end
            else
                pending_cr_next = pending_cr_reg + 2'd1;
        end
        else
        begin
            cr_cnt          = pending_cr_reg;
            tail_en         = 1'b1;
            tail_item       = '{out_unit: unit, has_unit: 1'b1, line_end: 1'b0};
            pending_cr_next = 2'd0;
            line_open_next  = 1'b1;
        end
    end

    always_comb
    begin
        cr0_item = '{out_unit: mels_pkg::UNIT_CR, has_unit: 1'b1, line_end: cr_end0};
        cr1_item = '{out_unit: mels_pkg::UNIT_CR, has_unit: 1'b1, line_end: cr_end1};
        res_n    = cr_cnt + {1'b0, tail_en};
        slot[0]  = (cr_cnt != 2'd0) ? cr0_item : tail_item;
        slot[1]  = (cr_cnt >= 2'd2) ? cr1_item : tail_item;
        slot[2]  = tail_item;
    end

    assign fire = in_vld_reg &&
                  ({1'b0, count_reg} + (mels_pkg::CNT_W + 1)'(res_n)
                   <= (mels_pkg::CNT_W + 1)'(mels_pkg::QUEUE_DEPTH));
    assign src_stall = in_vld_reg && !fire;
    assign accept    = src_valid && !src_stall;
    assign pop       = dst_valid && !dst_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (accept)
            in_vld_reg <= 1'b1;
        else if (fire)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= src_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_cr_reg <= 2'd0;
            line_open_reg  <= 1'b0;
        end
        else if (fire)
        begin
            pending_cr_reg <= pending_cr_next;
            line_open_reg  <= line_open_next;
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mels_pkg::MAX_RES; i++)
        begin
            if (fire && (2'(i) < res_n))
                queue_mem[wr_ptr_reg + mels_pkg::PTR_W'(i)] <= slot[i];
        end
    end

    assign count_next = count_reg + (fire ? mels_pkg::CNT_W'(res_n) : '0)
                        - (pop ? mels_pkg::CNT_W'(1) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (fire)
                wr_ptr_reg <= wr_ptr_reg + mels_pkg::PTR_W'(res_n);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + mels_pkg::PTR_W'(1);
            count_reg <= count_next;
        end
    end

    assign dst_valid = (count_reg != '0);
    assign dst_item  = queue_mem[rd_ptr_reg];

    // checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mels_pkg::CNT_W'(mels_pkg::QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_cr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_cr_reg != 2'd3)
        else $error("more than two CRs held");

    a_open_vs_cr: assert property (@(posedge clk) disable iff (!rst_n)
        !(line_open_reg && (pending_cr_reg != 2'd0)))
        else $error("open line while CRs are held");

    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_item_reg.op == mels_pkg::OP_EOF)
        |=> (pending_cr_reg == 2'd0) && !line_open_reg)
        else $error("end of file left state behind");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        mels_pkg::PTR_W'(count_reg) == (wr_ptr_reg - rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

FILE: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [mels_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [mels_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    // predicts the items coming out of the splitter and keeps them in order
    class line_end_board;
        bit                  wide_units;
        bit                  swap_bytes;
        int                  held_crs;
        bit                  line_open;
        int                  failures;
        mels_pkg::out_item_t expected_units[$];

        function new();
            wide_units = 1'b0;
            swap_bytes = 1'b0;
            held_crs   = 0;
            line_open  = 1'b0;
            failures   = 0;
        endfunction

        function void set_register(logic [mels_pkg::CFG_INDEX_W-1:0] index, logic value);
            if (index == mels_pkg::REG_WIDE_UNITS)
                wide_units = value;
            else if (index == mels_pkg::REG_SWAP_BYTES)
                swap_bytes = value;
        endfunction

        function void expect_unit(logic [15:0] unit, logic has, logic last);
            mels_pkg::out_item_t want;
            want.out_unit = unit;
            want.has_unit = has;
            want.line_end = last;
            expected_units.insert(expected_units.size(), want);
        endfunction

        function int outstanding();
            return expected_units.size();
        endfunction

        function void note_accepted(mels_pkg::in_item_t it);
            logic [15:0] u;
            if (it.op == mels_pkg::OP_EOF)
            begin
                if (held_crs == 1)
                begin
                    expect_unit(mels_pkg::UNIT_CR, 1'b1, 1'b1);
                end
                else if (held_crs == 2)
                begin
                    // cr cr stays one line at end of file
                    expect_unit(mels_pkg::UNIT_CR, 1'b1, 1'b0);
                    expect_unit(mels_pkg::UNIT_CR, 1'b1, 1'b1);
                end
                else if (line_open)
                begin
                    expect_unit(16'h0000, 1'b0, 1'b1);
                end
                held_crs  = 0;
                line_open = 1'b0;
                return;
            end
            if (!wide_units)
                u = {8'h00, it.code_unit[7:0]};
            else if (swap_bytes)
                u = {it.code_unit[7:0], it.code_unit[15:8]};
            else
                u = it.code_unit;
            if (u == mels_pkg::UNIT_LF)
            begin
                repeat (held_crs) expect_unit(mels_pkg::UNIT_CR, 1'b1, 1'b0);
                expect_unit(mels_pkg::UNIT_LF, 1'b1, 1'b1);
                held_crs  = 0;
                line_open = 1'b0;
            end
            else if (u == mels_pkg::UNIT_CR)
            begin
                if (held_crs == 2)
                begin
                    expect_unit(mels_pkg::UNIT_CR, 1'b1, 1'b1);
                    expect_unit(mels_pkg::UNIT_CR, 1'b1, 1'b1);
                    held_crs = 1;
                end
                else
                begin
                    held_crs++;
                end
                line_open = 1'b0;
            end
            else
            begin
                // each held cr closes a line of its own
                repeat (held_crs) expect_unit(mels_pkg::UNIT_CR, 1'b1, 1'b1);
                expect_unit(u, 1'b1, 1'b0);
                held_crs  = 0;
                line_open = 1'b1;
            end
        endfunction

        task report(string what);
            failures++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_emitted(mels_pkg::out_item_t got);
            mels_pkg::out_item_t want;
            if (expected_units.size() == 0)
            begin
                report($sformatf("item %h/%b/%b with nothing expected",
                                 got.out_unit, got.has_unit, got.line_end));
                return;
            end
            want = expected_units.pop_front();
            if (got.out_unit !== want.out_unit)
                report($sformatf("out_unit %h, expected %h", got.out_unit, want.out_unit));
            if (got.has_unit !== want.has_unit)
                report($sformatf("has_unit %b, expected %b (unit %h)",
                                 got.has_unit, want.has_unit, want.out_unit));
            if (got.line_end !== want.line_end)
                report($sformatf("line_end %b, expected %b (unit %h)",
                                 got.line_end, want.line_end, want.out_unit));
        endtask
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 src_valid;
    logic                                 src_stall;
    mels_pkg::in_item_t                   src_item;
    logic                                 dst_valid;
    logic                                 dst_stall;
    mels_pkg::out_item_t                  dst_item;
    logic                                 cfg_we;
    logic [mels_pkg::CFG_INDEX_W-1:0]     cfg_index;
    logic                                 cfg_data;

    line_end_board board;
    bit            src_steady;
    bit            dst_steady;
    int            hold_cycles;
    int            cycle_count;

    mels_pkg::in_item_t opening_script [25] = '{
        {mels_pkg::OP_UNIT, 16'h0061}, {mels_pkg::OP_UNIT, 16'h000A},
        {mels_pkg::OP_UNIT, 16'h0062}, {mels_pkg::OP_UNIT, 16'h000D},
        {mels_pkg::OP_UNIT, 16'h000A},
        {mels_pkg::OP_UNIT, 16'h000D}, {mels_pkg::OP_UNIT, 16'h000D},
        {mels_pkg::OP_UNIT, 16'h000A},
        {mels_pkg::OP_UNIT, 16'h000D}, {mels_pkg::OP_UNIT, 16'h0078},
        {mels_pkg::OP_UNIT, 16'h000D}, {mels_pkg::OP_UNIT, 16'h000D},
        {mels_pkg::OP_UNIT, 16'h0079},
        {mels_pkg::OP_UNIT, 16'h000D}, {mels_pkg::OP_UNIT, 16'h000D},
        {mels_pkg::OP_UNIT, 16'h000D},
        {mels_pkg::OP_EOF,  16'h0000},
        {mels_pkg::OP_UNIT, 16'hFFFF}, {mels_pkg::OP_EOF,  16'hFFFF},
        {mels_pkg::OP_EOF,  16'h0000},
        {mels_pkg::OP_UNIT, 16'hFF0D}, {mels_pkg::OP_UNIT, 16'h800D},
        {mels_pkg::OP_EOF,  16'h0000},
        {mels_pkg::OP_UNIT, 16'h0000}, {mels_pkg::OP_UNIT, 16'h7F0A}
    };

    mixed_eol_line_splitter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("mixed_eol_line_splitter regression: fail");
        $finish;
    end

    // receiver side: random stalls, quiet stretches and one long hold-off
    initial
    begin
        dst_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                dst_stall <= 1'b1;
                hold_cycles--;
            end
            else if (dst_steady)
                dst_stall <= 1'b0;
            else
                dst_stall <= ($urandom_range(99) < 18);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
            board.check_emitted(dst_item);
    end

    task automatic send_item(mels_pkg::in_item_t it);
        if (!src_steady)
        begin
            while ($urandom_range(99) < 18)
            begin
                src_valid <= 1'b0;
                @(posedge clk);
            end
        end
        src_valid <= 1'b1;
        src_item  <= it;
        @(posedge clk);
        while (src_stall) @(posedge clk);
        board.note_accepted(it);
    endtask

    task automatic write_reg(logic [mels_pkg::CFG_INDEX_W-1:0] index, logic value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        board.set_register(index, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // lets every expected item drain, plus time for items that give none
    task automatic settle();
        src_valid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic mels_pkg::in_item_t unit_item(logic [15:0] u);
        mels_pkg::in_item_t it;
        it.op = mels_pkg::OP_UNIT;
        if (!board.wide_units)
            it.code_unit = {8'($urandom), u[7:0]};
        else if (board.swap_bytes)
            it.code_unit = {u[7:0], u[15:8]};
        else
            it.code_unit = u;
        return it;
    endfunction

    function automatic logic [15:0] text_unit();
        logic [15:0] u;
        if (board.wide_units && $urandom_range(9) == 0)
        begin
            // near misses: cr or lf in the wrong byte
            case ($urandom_range(3))
                0: u = 16'h0D00;
                1: u = 16'h0A00;
                2: u = 16'h0A0D;
                default: u = 16'h0D0A;
            endcase
        end
        else
        begin
            do
                u = board.wide_units ? 16'($urandom) : {8'h00, 8'($urandom)};
            while (u == mels_pkg::UNIT_CR || u == mels_pkg::UNIT_LF);
        end
        return u;
    endfunction

    task automatic random_phase(int count);
        int                 sent;
        mels_pkg::in_item_t it;
        sent = 0;
        while (sent < count)
        begin
            repeat ($urandom_range(5))
            begin
                send_item(unit_item(text_unit()));
                sent++;
            end
            case ($urandom_range(9))
                0, 1:
                begin
                    send_item(unit_item(mels_pkg::UNIT_LF));
                    sent++;
                end
                2, 3:
                begin
                    send_item(unit_item(mels_pkg::UNIT_CR));
                    send_item(unit_item(mels_pkg::UNIT_LF));
                    sent += 2;
                end
                4:
                begin
                    repeat (2) send_item(unit_item(mels_pkg::UNIT_CR));
                    send_item(unit_item(mels_pkg::UNIT_LF));
                    sent += 3;
                end
                5:
                begin
                    send_item(unit_item(mels_pkg::UNIT_CR));
                    sent++;
                end
                6:
                begin
                    repeat (2) send_item(unit_item(mels_pkg::UNIT_CR));
                    sent += 2;
                end
                7:
                begin
                    repeat (3) send_item(unit_item(mels_pkg::UNIT_CR));
                    sent += 3;
                end
                8:
                begin
                    it.op        = mels_pkg::OP_EOF;
                    it.code_unit = 16'($urandom);
                    send_item(it);
                    sent++;
                end
                default:
                begin
                    // raw noise, any op and any word
                    repeat (3)
                    begin
                        it.op        = ($urandom_range(7) == 0) ? mels_pkg::OP_EOF
                                                                : mels_pkg::OP_UNIT;
                        it.code_unit = 16'($urandom);
                        send_item(it);
                    end
                    sent += 3;
                end
            endcase
        end
    endtask

    initial
    begin
        board       = new();
        src_steady  = 1'b0;
        dst_steady  = 1'b0;
        hold_cycles = 0;
        cycle_count = 0;
        rst_n       = 1'b0;
        src_valid   <= 1'b0;
        src_item    <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= mels_pkg::REG_WIDE_UNITS;
        cfg_data    <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte mode, unused indexes must change nothing
        write_reg(mels_pkg::REG_WIDE_UNITS, 1'b0);
        write_reg(mels_pkg::REG_SWAP_BYTES, 1'b0);
        write_reg(REG_SPARE_2, 1'b1);
        write_reg(REG_SPARE_3, 1'b1);
        foreach (opening_script[i])
            send_item(opening_script[i]);
        random_phase(45);
        settle();

        // 16-bit units, with a long receiver hold-off to back up the block
        write_reg(mels_pkg::REG_WIDE_UNITS, 1'b1);
        hold_cycles = 150;
        random_phase(55);
        settle();

        write_reg(mels_pkg::REG_SWAP_BYTES, 1'b1);
        src_steady = 1'b1;
        dst_steady = 1'b1;
        random_phase(50);
        src_steady = 1'b0;
        dst_steady = 1'b0;
        settle();

        // swap has no effect on bytes
        write_reg(mels_pkg::REG_WIDE_UNITS, 1'b0);
        random_phase(45);
        settle();

        write_reg(mels_pkg::REG_WIDE_UNITS, 1'b1);
        write_reg(mels_pkg::REG_SWAP_BYTES, 1'b0);
        random_phase(45);
        settle();

        if (board.outstanding() != 0)
            board.report($sformatf("%0d items never came out", board.outstanding()));
        if (board.failures == 0)
            $display("mixed_eol_line_splitter regression: pass");
        else
            $display("mixed_eol_line_splitter regression: fail");
        $finish;
    end

endmodule
